>>> hw/rtl/fvdm_pkg.sv
package fvdm_pkg;

	localparam int VOICE_COUNT      = 4;
	localparam int OVERSAMPLE       = 6;
	localparam int MAX_LENGTH_WORDS = 320;
	localparam int SAMPLE_MEM_DEPTH = 4096;

	localparam int CFG_W = 48;

	localparam logic [2:0] OP_FRAME  = 3'd0;
	localparam logic [2:0] OP_BYTE   = 3'd1;
	localparam logic [2:0] OP_PERIOD = 3'd2;
	localparam logic [2:0] OP_VOLUME = 3'd3;
	localparam logic [2:0] OP_LENGTH = 3'd4;
	localparam logic [2:0] OP_START  = 3'd5;
	localparam logic [2:0] OP_DMA_ON = 3'd6;
	localparam logic [2:0] OP_STOP   = 3'd7;

	localparam logic [2:0] REG_DELTA_NUM = 3'd0;
	localparam logic [2:0] REG_AVG_MUL   = 3'd1;
	localparam logic [2:0] REG_MASTER    = 3'd2;
	localparam logic [2:0] REG_SEP       = 3'd3;
	localparam logic [2:0] REG_SPT       = 3'd4;
	localparam logic [2:0] REG_PAUSE     = 3'd5;

	localparam logic [16:0] PERIOD_MIN  = 17'd113;
	localparam logic [16:0] PERIOD_ZERO = 17'd65536;
	localparam logic [6:0]  VOLUME_MAX  = 7'd64;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [1:0]         voice;
		logic [15:0]        value;
		logic [11:0]        address;
		logic signed [7:0]  sample_byte;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               tick_due;
	} out_req_t;

	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/fvdm_div.sv
module fvdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fvdm_pkg::div_req_t req,
	output fvdm_pkg::div_rsp_t rsp
);

	logic [39:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[39]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd40;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[17]) begin
					rem_q <= trial[16:0];
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= {rem_q[15:0], quo_q[39]};
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = (quo_q[39:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("div done without busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 6'd0)) else $error("div busy with zero count");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("div did not start");

endmodule

>>> hw/rtl/four_voice_dma_sample_mixer.sv
// Four-voice sample mixer.
// in channel (in_valid/in_stall/in_data): one request per opcode. Opcode 0
// asks for one stereo frame and gives one out request; every other opcode
// writes memory or voice registers and gives nothing.
// out channel (out_valid/out_stall/out_data): left, right and tick flag.
// cfg port (cfg_we/cfg_index/cfg_data): to be written only while idle; the block does not enforce it.
// A single sequencer takes one request at a time. A frame walks the four
// voices over one shared add/step path, OVERSAMPLE steps per running voice,
// skipping stopped voices and refetching sample bytes as needed; then one
// shared multiplier serves the average of each voice, then normalisation
// and mid/side in NORM_L, NORM_R, MID and SIDE before OUT. A period write
// that changes the cached period goes through a restoring divider. Start
// DMA reads two bytes per voice; other writes use the write state only.
// The result waits in the output register; a non-frame request is taken
// while it waits, but a further frame holds until the register is free.
// Reset clears all voice state, the tick counter and config to defaults;
// sample memory is undefined until written.
module four_voice_dma_sample_mixer #(
	parameter int OVERSAMPLE       = fvdm_pkg::OVERSAMPLE,
	parameter int MAX_LENGTH_WORDS = fvdm_pkg::MAX_LENGTH_WORDS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fvdm_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fvdm_pkg::out_req_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [fvdm_pkg::CFG_W-1:0] cfg_data
);

	localparam int SAMPLE_MEM_DEPTH = fvdm_pkg::SAMPLE_MEM_DEPTH;
	localparam int AW  = $clog2(SAMPLE_MEM_DEPTH);
	localparam int LW  = $clog2(MAX_LENGTH_WORDS + 1);
	localparam int OSW = $clog2(OVERSAMPLE + 1);
	localparam int NV  = fvdm_pkg::VOICE_COUNT;

	typedef enum logic [4:0] {
		S_IDLE, S_WRITE, S_DIV, S_DIVW,
		S_DMA_RD0, S_DMA_RD1, S_DMA_RD2, S_DMA_NXT,
		S_V_START, S_V_STEP, S_F_RD0, S_F_RD1, S_F_RD2, S_V_AVG, S_V_AVG2,
		S_NORM_L, S_NORM_R, S_MID, S_SIDE, S_OUT
	} state_t;

	state_t state_q;

	logic [39:0] dnum_q;
	logic [30:0] amul_q;
	logic [8:0]  mvol_q;
	logic [6:0]  sep_q;
	logic [47:0] spt_q;
	logic        pause_q;

	logic [16:0] cper_q [NV];
	logic [31:0] pdel_q [NV];
	logic [31:0] adel_q [NV];
	logic [31:0] phase_q [NV];
	logic [6:0]  vol_q [NV];
	logic [LW-1:0] lenw_q [NV];
	logic [LW-1:0] lenr_q [NV];
	logic [AW-1:0] sadr_q [NV];
	logic [AW-1:0] fadr_q [NV];
	logic [7:0]  buf0_q [NV];
	logic [7:0]  buf1_q [NV];
	logic [1:0]  bcnt_q [NV];
	logic signed [13:0] lvl_q [NV];
	logic [NV-1:0] run_q;
	logic [63:0] tick_q;

	logic [7:0] mem [SAMPLE_MEM_DEPTH];
	logic [7:0] rd_q;
	logic [AW-1:0] rd_adr;
	logic       rd_en;
	logic       wr_en;

	fvdm_pkg::in_req_t req_q;
	logic [1:0]  vi_q;
	logic [OSW-1:0] k_q;
	logic signed [19:0] sum_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] mixl_q;
	logic signed [31:0] mixr_q;
	logic signed [63:0] lq_q;
	logic signed [63:0] rq_q;
	logic signed [63:0] mid_q;
	logic        due_q;

	logic signed [35:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [67:0] mul_p;

	fvdm_pkg::div_req_t dreq;
	fvdm_pkg::div_rsp_t drsp;

	fvdm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [16:0] per_cl;
	logic [6:0]  vol_cl;
	logic [LW-1:0] len_cl;
	logic [32:0] ph_sum;
	logic signed [18:0] norm_c;
	logic [15:0] side_c;
	logic signed [63:0] lsum;
	logic signed [63:0] rsum;
	logic signed [15:0] lsat;
	logic signed [15:0] rsat;
	logic               accept;

	function automatic logic [LW-1:0] clamp_len(input logic [15:0] v);
		logic [LW-1:0] r;
		if (v == 16'd0) r = LW'(1);
		else if (32'(v) > MAX_LENGTH_WORDS) r = LW'(MAX_LENGTH_WORDS);
		else r = LW'(v);
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
		logic signed [15:0] r;
		if (x > 64'sd32767) r = 16'sh7FFF;
		else if (x < -64'sd32768) r = -16'sh8000;
		else r = x[15:0];
		return r;
	endfunction

	function automatic logic signed [63:0] div32t(input logic signed [63:0] x);
		logic signed [63:0] r;
		if (x < 0) r = -64'(($unsigned(-x)) >> 32);
		else r = 64'($unsigned(x) >> 32);
		return r;
	endfunction

	assign in_stall = (state_q != S_IDLE) || (out_valid && in_data.opcode == fvdm_pkg::OP_FRAME);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		per_cl = {1'b0, req_q.value};
		if (req_q.value == 16'd0) per_cl = fvdm_pkg::PERIOD_ZERO;
		else if ({1'b0, req_q.value} < fvdm_pkg::PERIOD_MIN) per_cl = fvdm_pkg::PERIOD_MIN;
		vol_cl = (req_q.value[6:0] > fvdm_pkg::VOLUME_MAX) ? fvdm_pkg::VOLUME_MAX
			: req_q.value[6:0];
		len_cl = clamp_len(req_q.value);
		ph_sum = {1'b0, phase_q[vi_q]} + {1'b0, adel_q[vi_q]};
		norm_c = -19'sd1 * $signed({1'b0, 18'((27'(mvol_q) * 27'd98301) >> 8)});
		// sep * 32768 / 100 by reciprocal, exact for 7-bit sep
		side_c = 16'((28'(sep_q) * 28'd1342178) >> 12);
		lsum   = mid_q + acc_q;
		rsum   = mid_q - acc_q;
		lsat   = sat16(div32t(lsum));
		rsat   = sat16(div32t(rsum));
	end

	always_comb begin
		mul_a = {{16{sum_q[19]}}, sum_q};
		mul_b = {1'b0, amul_q};
		case (state_q)
			S_NORM_L: begin mul_a = 36'(mixl_q); mul_b = 32'(norm_c); end
			S_NORM_R: begin mul_a = 36'(mixr_q); mul_b = 32'(norm_c); end
			S_MID:    begin mul_a = 36'(lq_q + rq_q); mul_b = 32'sd32768; end
			S_SIDE:   begin mul_a = 36'(lq_q - rq_q); mul_b = $signed({16'd0, side_c}); end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		rd_en  = 1'b0;
		rd_adr = fadr_q[vi_q];
		wr_en  = (state_q == S_WRITE) && (req_q.opcode == fvdm_pkg::OP_BYTE);
		case (state_q)
			S_DMA_RD0, S_DMA_RD1, S_F_RD0, S_F_RD1: rd_en = 1'b1;
			default: ;
		endcase
		dreq.start    = (state_q == S_DIV);
		dreq.dividend = dnum_q;
		dreq.divisor  = per_cl;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[req_q.address[AW-1:0]] <= req_q.sample_byte;
		if (rd_en) rd_q <= mem[rd_adr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			dnum_q    <= 40'd52895128000;
			amul_q    <= 31'd715827883;
			mvol_q    <= 9'd256;
			sep_q     <= 7'd20;
			spt_q     <= 48'd4123168604160;
			pause_q   <= 1'b0;
			tick_q    <= '0;
			run_q     <= '0;
			vi_q      <= '0;
			k_q       <= '0;
			for (int i = 0; i < NV; i++) begin
				cper_q[i]  <= '1;
				pdel_q[i]  <= '0;
				adel_q[i]  <= '0;
				phase_q[i] <= '0;
				vol_q[i]   <= '0;
				lenw_q[i]  <= LW'(1);
				lenr_q[i]  <= LW'(1);
				sadr_q[i]  <= '0;
				fadr_q[i]  <= '0;
				buf0_q[i]  <= '0;
				buf1_q[i]  <= '0;
				bcnt_q[i]  <= '0;
				lvl_q[i]   <= '0;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					fvdm_pkg::REG_DELTA_NUM: dnum_q  <= cfg_data[39:0];
					fvdm_pkg::REG_AVG_MUL:   amul_q  <= cfg_data[30:0];
					fvdm_pkg::REG_MASTER:    mvol_q  <= cfg_data[8:0];
					fvdm_pkg::REG_SEP:       sep_q   <= cfg_data[6:0];
					fvdm_pkg::REG_SPT:       spt_q   <= cfg_data[47:0];
					fvdm_pkg::REG_PAUSE:     pause_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (accept) begin
					req_q <= in_data;
					vi_q  <= '0;
					if (in_data.opcode == fvdm_pkg::OP_FRAME) begin
						if (pause_q) begin
							out_data  <= '0;
							out_valid <= 1'b1;
						end else begin
							due_q  <= (tick_q == 64'd0) || tick_q[63];
							if ((tick_q == 64'd0) || tick_q[63])
								tick_q <= tick_q + 64'(spt_q);
							mixl_q <= '0;
							mixr_q <= '0;
							state_q <= S_V_START;
						end
					end else if (in_data.opcode == fvdm_pkg::OP_DMA_ON)
						state_q <= S_DMA_NXT;
					else
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					state_q <= S_IDLE;
					case (req_q.opcode)
						fvdm_pkg::OP_PERIOD:
							if (per_cl != cper_q[req_q.voice]) state_q <= S_DIV;
						fvdm_pkg::OP_VOLUME: vol_q[req_q.voice] <= vol_cl;
						fvdm_pkg::OP_LENGTH: lenw_q[req_q.voice] <= len_cl;
						fvdm_pkg::OP_START:  sadr_q[req_q.voice] <= req_q.address[AW-1:0];
						fvdm_pkg::OP_STOP: begin
							run_q <= '0;
							for (int i = 0; i < NV; i++) begin
								sadr_q[i] <= '0;
								fadr_q[i] <= '0;
								lenw_q[i] <= LW'(1);
								lenr_q[i] <= LW'(1);
							end
						end
						default: ;
					endcase
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (drsp.done) begin
					cper_q[req_q.voice] <= per_cl;
					pdel_q[req_q.voice] <= drsp.quotient;
					state_q <= S_IDLE;
				end
				S_DMA_NXT: begin
					adel_q[vi_q]  <= pdel_q[vi_q];
					fadr_q[vi_q]  <= sadr_q[vi_q];
					lenr_q[vi_q]  <= lenw_q[vi_q];
					phase_q[vi_q] <= '0;
					run_q[vi_q]   <= 1'b1;
					state_q       <= S_DMA_RD0;
				end
				S_DMA_RD0: begin
					fadr_q[vi_q] <= fadr_q[vi_q] + AW'(1);
					state_q <= S_DMA_RD1;
				end
				S_DMA_RD1: begin
					fadr_q[vi_q] <= fadr_q[vi_q] + AW'(1);
					buf0_q[vi_q] <= rd_q;
					state_q <= S_DMA_RD2;
				end
				S_DMA_RD2: begin
					lvl_q[vi_q]  <= 14'($signed(buf0_q[vi_q]) * $signed({1'b0, vol_q[vi_q]}));
					buf0_q[vi_q] <= rd_q;
					buf1_q[vi_q] <= rd_q;
					bcnt_q[vi_q] <= 2'd1;
					vi_q <= vi_q + 2'd1;
					state_q <= (vi_q == 2'(NV - 1)) ? S_IDLE : S_DMA_NXT;
				end
				S_V_START: begin
					sum_q <= '0;
					k_q   <= '0;
					if (run_q[vi_q]) state_q <= S_V_STEP;
					else if (vi_q == 2'(NV - 1)) state_q <= S_NORM_L;
					else vi_q <= vi_q + 2'd1;
				end
				S_V_STEP: begin
					sum_q <= sum_q + 20'(lvl_q[vi_q]);
					phase_q[vi_q] <= ph_sum[31:0];
					k_q <= k_q + OSW'(1);
					if (ph_sum[32]) begin
						adel_q[vi_q] <= pdel_q[vi_q];
						if (bcnt_q[vi_q] == 2'd0) begin
							if (lenr_q[vi_q] <= LW'(1)) begin
								lenr_q[vi_q] <= lenw_q[vi_q];
								fadr_q[vi_q] <= sadr_q[vi_q];
							end else
								lenr_q[vi_q] <= lenr_q[vi_q] - LW'(1);
							state_q <= S_F_RD0;
						end else begin
							lvl_q[vi_q] <= 14'($signed(buf0_q[vi_q]) *
								$signed({1'b0, vol_q[vi_q]}));
							buf0_q[vi_q] <= buf1_q[vi_q];
							bcnt_q[vi_q] <= bcnt_q[vi_q] - 2'd1;
							if (k_q == OSW'(OVERSAMPLE - 1)) state_q <= S_V_AVG;
						end
					end else if (k_q == OSW'(OVERSAMPLE - 1))
						state_q <= S_V_AVG;
				end
				S_F_RD0: begin
					fadr_q[vi_q] <= fadr_q[vi_q] + AW'(1);
					state_q <= S_F_RD1;
				end
				S_F_RD1: begin
					fadr_q[vi_q] <= fadr_q[vi_q] + AW'(1);
					buf0_q[vi_q] <= rd_q;
					state_q <= S_F_RD2;
				end
				S_F_RD2: begin
					lvl_q[vi_q]  <= 14'($signed(buf0_q[vi_q]) * $signed({1'b0, vol_q[vi_q]}));
					buf0_q[vi_q] <= rd_q;
					buf1_q[vi_q] <= rd_q;
					bcnt_q[vi_q] <= 2'd1;
					state_q <= (k_q == OSW'(OVERSAMPLE)) ? S_V_AVG : S_V_STEP;
				end
				S_V_AVG: begin
					acc_q   <= mul_p[63:0];
					state_q <= S_V_AVG2;
				end
				S_V_AVG2: begin
					if (vi_q == 2'd0 || vi_q == 2'd3)
						mixl_q <= mixl_q + 32'(acc_q >>> 32);
					else
						mixr_q <= mixr_q + 32'(acc_q >>> 32);
					if (vi_q == 2'(NV - 1)) state_q <= S_NORM_L;
					else begin
						vi_q <= vi_q + 2'd1;
						state_q <= S_V_START;
					end
				end
				S_NORM_L: begin lq_q <= mul_p[63:0]; state_q <= S_NORM_R; end
				S_NORM_R: begin rq_q <= mul_p[63:0]; state_q <= S_MID; end
				S_MID:    begin mid_q <= mul_p[63:0]; state_q <= S_SIDE; end
				S_SIDE:   begin acc_q <= mul_p[63:0]; state_q <= S_OUT; end
				S_OUT: begin
					out_data.left_out  <= lsat;
					out_data.right_out <= rsat;
					out_data.tick_due  <= due_q;
					out_valid <= 1'b1;
					tick_q    <= tick_q - 64'h1_0000_0000;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !out_valid || !out_stall) else $error("result overwritten");
	a_div_only_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVW) |-> (req_q.opcode == fvdm_pkg::OP_PERIOD))
		else $error("divider used outside period write");

endmodule
